// ----- sv/nlrr_pkg.sv -----
// ============================================================================
// nlrr_pkg
// Shared types and constants for the NR LDPC rate recovery block.
// ============================================================================
package nlrr_pkg;

    localparam int DEF_MAX_LLRS   = 32768;
    localparam int DEF_MAX_BUFFER = 32768;

    // position arithmetic width (signed, covers buffer and filler bounds)
    localparam int POS_W = 18;

    localparam int LLR_W  = 8;
    localparam int SOFT_W = 12;
    localparam int IDX_W  = 15;

    localparam logic signed [SOFT_W-1:0] SOFT_MAX = 12'sd2047;
    localparam logic signed [SOFT_W-1:0] SOFT_MIN = -12'sd2048;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_BASE_GRAPH   = 3'd0;
    localparam logic [2:0] REG_LIFTING_SIZE = 3'd1;
    localparam logic [2:0] REG_FILLER_BITS  = 3'd2;
    localparam logic [2:0] REG_START_OFFSET = 3'd3;
    localparam logic [2:0] REG_BUFFER_SIZE  = 3'd4;
    localparam logic [2:0] REG_MOD_ORDER    = 3'd5;

    typedef struct packed {
        logic push;        // store one LLR
        logic pass_start;  // latch block geometry, arm clear and divide
        logic read_issue;  // read buffer entry for a read word
        logic read_capture;
        logic clear_step;  // write one clear/filler entry
        logic mark;        // clear pass marks fillers
        logic div_step;
        logic acc_init;
        logic skip_jump;
        logic acc_read;
        logic acc_write;
    } nlrr_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic pass_empty;
        logic idx_filler;
        logic acc_last;
    } nlrr_sts_t;

endpackage

// ----- sv/nlrr_in_if.sv -----
// ============================================================================
// nlrr_in_if
// Input word channel: push LLR or read buffer entry.
// ============================================================================
interface nlrr_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic signed [7:0] llr;
    logic        last;
    logic [14:0] read_index;

    modport source (output valid, kind, llr, last, read_index, input ready);
    modport sink   (input valid, kind, llr, last, read_index, output ready);
endinterface

// ----- sv/nlrr_out_if.sv -----
// ============================================================================
// nlrr_out_if
// Result word channel: one soft value per read word.
// ============================================================================
interface nlrr_out_if;
    logic        valid;
    logic        ready;
    logic signed [11:0] soft_value;

    modport source (output valid, soft_value, input ready);
    modport sink   (input valid, soft_value, output ready);
endinterface

// ----- sv/nlrr_ram.sv -----
// ============================================================================
// nlrr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module nlrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/nlrr_ctrl.sv -----
// ============================================================================
// nlrr_ctrl
// Sequencer: word handshake, clear pass, divide, accumulate walk.
// ============================================================================
module nlrr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_kind,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nlrr_pkg::nlrr_cmd_t   cmd,
    input  nlrr_pkg::nlrr_sts_t   sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_DIV,
        S_CHECK,
        S_SKIP,
        S_ACC_RD,
        S_ACC_WR
    } state_t;

    state_t state_reg, state_next;
    logic   in_pass_reg, in_pass_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        in_pass_next   = in_pass_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_kind == nlrr_pkg::KIND_READ)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_READ;
                end
                else if (accept)
                begin
                    cmd.push = 1'b1;
                    if (in_last)
                    begin
                        cmd.pass_start = 1'b1;
                        in_pass_next   = 1'b1;
                        state_next     = S_CLEAR;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_capture = 1'b1;
                out_valid_next   = 1'b1;
                state_next       = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cmd.mark       = in_pass_reg;
                if (sts.clear_done)
                begin
                    state_next = in_pass_reg ? S_DIV : S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.acc_init = 1'b1;
                if (sts.pass_empty)
                begin
                    in_pass_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (sts.idx_filler)
                begin
                    cmd.skip_jump = 1'b1;
                end
                else
                begin
                    cmd.acc_read = 1'b1;
                    state_next   = S_ACC_RD;
                end
            end
            S_ACC_RD:
            begin
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                cmd.acc_write = 1'b1;
                if (sts.acc_last)
                begin
                    in_pass_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_SKIP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            in_pass_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_pass_reg   <= in_pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/nlrr_dp.sv -----
// ============================================================================
// nlrr_dp
// Datapath: LLR store, soft buffer, divider, de-interleave address, saturating add.
// ============================================================================
module nlrr_dp #(
    parameter int MAX_LLRS   = nlrr_pkg::DEF_MAX_LLRS,
    parameter int MAX_BUFFER = nlrr_pkg::DEF_MAX_BUFFER
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nlrr_pkg::nlrr_cmd_t        cmd,
    output nlrr_pkg::nlrr_sts_t        sts,
    input  logic signed [7:0]          llr,
    input  logic [14:0]                read_index,
    input  logic [1:0]                 base_graph,
    input  logic [8:0]                 lifting_size,
    input  logic [13:0]                filler_bits,
    input  logic [14:0]                start_offset,
    input  logic [14:0]                buffer_size,
    input  logic [3:0]                 mod_order,
    output logic signed [11:0]         soft_value
);

    localparam int PW   = nlrr_pkg::POS_W;
    localparam int AWL  = $clog2(MAX_LLRS);
    localparam int AWB  = $clog2(MAX_BUFFER);
    localparam int CW   = AWL + 1;
    localparam int DS   = (CW > 15) ? CW : 15;
    localparam int DCW  = $clog2(DS + 1);

    // ---------------- LLR store ----------------
    logic [CW-1:0]  llr_count_reg;
    logic           store_full;
    logic [AWL-1:0] store_raddr;
    logic [7:0]     store_rdata;

    assign store_full = (llr_count_reg == CW'(MAX_LLRS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            llr_count_reg <= '0;
        end
        else if (cmd.pass_start)
        begin
            llr_count_reg <= '0;
        end
        else if (cmd.push && !store_full)
        begin
            llr_count_reg <= llr_count_reg + CW'(1);
        end
    end

    nlrr_ram #(.WIDTH(8), .DEPTH(MAX_LLRS)) u_store (
        .clk   (clk),
        .we    (cmd.push && !store_full),
        .waddr (llr_count_reg[AWL-1:0]),
        .wdata (llr),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // ---------------- block geometry ----------------
    logic [CW-1:0]        e_reg;
    logic [3:0]           qm_reg;
    logic signed [PW-1:0] fend_reg, lo_reg, ncb_reg;
    logic signed [PW-1:0] zc_ext, fend_c, fstart_c, bs_ext;

    assign zc_ext   = PW'(lifting_size);
    assign fend_c   = (base_graph == 2'd2) ? (zc_ext <<< 3) : ((zc_ext <<< 4) + (zc_ext <<< 2));
    assign fstart_c = fend_c - PW'(filler_bits);
    assign bs_ext   = PW'(buffer_size);

    // ---------------- divider: e / qm and k0 % ncb ----------------
    logic [DS-1:0]   q_sh_reg, k_sh_reg;
    logic [3:0]      rem_q_reg;
    logic [PW-2:0]   rem_k_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic [4:0]      rq;
    logic            rq_ge;
    logic [PW-1:0]   rk;
    logic            rk_ge;

    assign rq    = {rem_q_reg, q_sh_reg[DS-1]};
    assign rq_ge = (rq >= {1'b0, qm_reg});
    assign rk    = {rem_k_reg, k_sh_reg[DS-1]};
    assign rk_ge = ($signed(rk) >= ncb_reg);

    // ---------------- walk state ----------------
    logic [CW-1:0]        i_reg, q_reg, rowbase_reg, row;
    logic [3:0]           col_reg;
    logic signed [PW-1:0] idx_reg, idx_inc;
    logic [AWB-1:0]       p_reg;
    logic signed [PW-1:0] p_ext, hi_c, nfill_c;
    logic                 p_filler;

    assign row     = q_sh_reg[CW-1:0];
    assign idx_inc = idx_reg + PW'(1);
    assign p_ext   = PW'(p_reg);
    assign p_filler = (p_ext >= lo_reg) && (p_ext < fend_reg);
    assign hi_c    = (fend_reg < ncb_reg) ? fend_reg : ncb_reg;
    assign nfill_c = (hi_c > lo_reg) ? (hi_c - lo_reg) : '0;

    assign store_raddr = AWL'(q_reg + rowbase_reg);

    assign sts.clear_done = (p_reg == AWB'(MAX_BUFFER - 1));
    assign sts.div_done   = (dcnt_reg == DCW'(DS - 1));
    assign sts.pass_empty = (e_reg == '0) || (nfill_c >= ncb_reg);
    assign sts.idx_filler = (idx_reg >= lo_reg) && (idx_reg < fend_reg);
    assign sts.acc_last   = (i_reg == e_reg - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            p_reg <= sts.clear_done ? '0 : p_reg + AWB'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
        begin
            e_reg     <= store_full ? llr_count_reg : llr_count_reg + CW'(1);
            qm_reg    <= (mod_order == 4'd0) ? 4'd1 : mod_order;
            fend_reg  <= fend_c;
            lo_reg    <= fstart_c[PW-1] ? '0 : fstart_c;
            if (buffer_size == '0)
            begin
                ncb_reg <= PW'(1);
            end
            else if (bs_ext > PW'(MAX_BUFFER))
            begin
                ncb_reg <= PW'(MAX_BUFFER);
            end
            else
            begin
                ncb_reg <= bs_ext;
            end
            q_sh_reg  <= store_full ? DS'(llr_count_reg) : DS'(llr_count_reg + CW'(1));
            k_sh_reg  <= DS'(start_offset);
            rem_q_reg <= '0;
            rem_k_reg <= '0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            q_sh_reg  <= {q_sh_reg[DS-2:0], rq_ge};
            k_sh_reg  <= {k_sh_reg[DS-2:0], 1'b0};
            rem_q_reg <= rq_ge ? 4'(rq - {1'b0, qm_reg}) : rq[3:0];
            rem_k_reg <= rk_ge ? (PW-1)'(rk - ncb_reg) : rk[PW-2:0];
            dcnt_reg  <= dcnt_reg + DCW'(1);
        end

        if (cmd.acc_init)
        begin
            idx_reg     <= PW'(rem_k_reg);
            i_reg       <= '0;
            q_reg       <= '0;
            rowbase_reg <= '0;
            col_reg     <= '0;
        end
        else if (cmd.skip_jump)
        begin
            idx_reg <= (fend_reg >= ncb_reg) ? '0 : fend_reg;
        end
        else if (cmd.acc_write)
        begin
            idx_reg <= (idx_inc >= ncb_reg) ? '0 : idx_inc;
            i_reg   <= i_reg + CW'(1);
            if (col_reg == qm_reg - 4'd1)
            begin
                col_reg     <= '0;
                rowbase_reg <= '0;
                q_reg       <= q_reg + CW'(1);
            end
            else
            begin
                col_reg     <= col_reg + 4'd1;
                rowbase_reg <= rowbase_reg + row;
            end
        end
    end

    // ---------------- soft buffer ----------------
    logic                    buf_we;
    logic [AWB-1:0]          buf_waddr, buf_raddr;
    logic [11:0]             buf_wdata, buf_rdata;
    logic signed [12:0]      sum;
    logic signed [11:0]      sat;
    logic signed [PW-1:0]    ri_ext;
    logic                    oor_reg;

    assign ri_ext = PW'(read_index);
    assign sum    = 13'(signed'(buf_rdata)) + 13'(signed'(store_rdata));
    assign sat    = (sum > 13'(nlrr_pkg::SOFT_MAX)) ? nlrr_pkg::SOFT_MAX :
                    (sum < 13'(nlrr_pkg::SOFT_MIN)) ? nlrr_pkg::SOFT_MIN : sum[11:0];

    always_comb
    begin
        buf_we    = 1'b0;
        buf_waddr = p_reg;
        buf_wdata = (cmd.mark && p_filler) ? nlrr_pkg::SOFT_MAX : '0;
        if (cmd.clear_step)
        begin
            buf_we = 1'b1;
        end
        else if (cmd.acc_write)
        begin
            buf_we    = 1'b1;
            buf_waddr = idx_reg[AWB-1:0];
            buf_wdata = sat;
        end
        buf_raddr = cmd.read_issue ? ri_ext[AWB-1:0] : idx_reg[AWB-1:0];
    end

    nlrr_ram #(.WIDTH(12), .DEPTH(MAX_BUFFER)) u_soft (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.read_issue)
        begin
            oor_reg <= (ri_ext >= PW'(MAX_BUFFER));
        end
        if (cmd.read_capture)
        begin
            soft_value <= oor_reg ? '0 : buf_rdata;
        end
    end

endmodule

// ----- sv/nr_ldpc_rate_recovery.sv -----
// Pushes: one word per cycle while idle with no result pending. Reads: the result passes
//   the registered buffer read and the output register, and no word is taken until it leaves.
// After the last LLR: a clear pass over the soft buffer, the divider, then a walk that reads
//   and writes each LLR's entry, plus a jump per filler skip; no words taken meanwhile.
// Reset: async active low; a clearing pass of the soft buffer follows reset,
//   during which no words are taken (register writes still work).
// ============================================================================
// nr_ldpc_rate_recovery
// NR LDPC rate dematching for one code block: store LLRs, de-interleave,
// fill-mark and accumulate into a saturating circular soft buffer.
// ============================================================================
module nr_ldpc_rate_recovery #(
    parameter int MAX_LLRS   = nlrr_pkg::DEF_MAX_LLRS,
    parameter int MAX_BUFFER = nlrr_pkg::DEF_MAX_BUFFER
) (
    input  logic                         clk,
    input  logic                         rst_n,
    nlrr_in_if.sink                      items,
    nlrr_out_if.source                   results,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nlrr_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ---------------- configuration registers ----------------
    logic [1:0]  base_graph_reg;
    logic [8:0]  lifting_size_reg;
    logic [13:0] filler_bits_reg;
    logic [14:0] start_offset_reg;
    logic [14:0] buffer_size_reg;
    logic [3:0]  mod_order_reg;
    logic [2:0]  reg_sel;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_graph_reg   <= 2'd1;
            lifting_size_reg <= 9'd2;
            filler_bits_reg  <= '0;
            start_offset_reg <= '0;
            buffer_size_reg  <= 15'd25344;
            mod_order_reg    <= 4'd2;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                nlrr_pkg::REG_BASE_GRAPH:   base_graph_reg   <= pwdata[1:0];
                nlrr_pkg::REG_LIFTING_SIZE: lifting_size_reg <= pwdata[8:0];
                nlrr_pkg::REG_FILLER_BITS:  filler_bits_reg  <= pwdata[13:0];
                nlrr_pkg::REG_START_OFFSET: start_offset_reg <= pwdata[14:0];
                nlrr_pkg::REG_BUFFER_SIZE:  buffer_size_reg  <= pwdata[14:0];
                nlrr_pkg::REG_MOD_ORDER:    mod_order_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            nlrr_pkg::REG_BASE_GRAPH:   prdata = 32'(base_graph_reg);
            nlrr_pkg::REG_LIFTING_SIZE: prdata = 32'(lifting_size_reg);
            nlrr_pkg::REG_FILLER_BITS:  prdata = 32'(filler_bits_reg);
            nlrr_pkg::REG_START_OFFSET: prdata = 32'(start_offset_reg);
            nlrr_pkg::REG_BUFFER_SIZE:  prdata = 32'(buffer_size_reg);
            nlrr_pkg::REG_MOD_ORDER:    prdata = 32'(mod_order_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- controller and datapath ----------------
    nlrr_pkg::nlrr_cmd_t cmd;
    nlrr_pkg::nlrr_sts_t sts;

    nlrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_kind   (items.kind),
        .in_last   (items.last),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    nlrr_dp #(
        .MAX_LLRS   (MAX_LLRS),
        .MAX_BUFFER (MAX_BUFFER)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .llr          (items.llr),
        .read_index   (items.read_index),
        .base_graph   (base_graph_reg),
        .lifting_size (lifting_size_reg),
        .filler_bits  (filler_bits_reg),
        .start_offset (start_offset_reg),
        .buffer_size  (buffer_size_reg),
        .mod_order    (mod_order_reg),
        .soft_value   (results.soft_value)
    );

`ifndef SYNTHESIS
    // a result word only appears right after a buffer read was captured
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(cmd.read_capture))
        else $error("result word without a read");

    // input is only taken while the output register is empty
    a_ready_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !results.valid)
        else $error("input ready while result pending");

    // no words taken while the clear pass or the accumulate walk writes the buffer
    a_no_take_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_write || cmd.clear_step) |-> !items.ready)
        else $error("input ready during pass");
`endif

endmodule

// ----- verif/nr_ldpc_rate_recovery_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// nr_ldpc_rate_recovery_test
// Self-checking bench for the NR LDPC rate recovery block. Pushes code
// blocks of LLRs and issues buffer reads under several register settings.
// Each read result is compared with an in-bench model of the
// de-interleave, filler marking and saturating accumulation.
// ============================================================================
module nr_ldpc_rate_recovery_test;

    // One input word as the driver sees it.
    typedef struct {
        logic              kind;
        logic signed [7:0] llr;
        logic              last;
        logic [14:0]       idx;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [nlrr_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nlrr_in_if  items_if ();
    nlrr_out_if results_if ();

    nr_ldpc_rate_recovery DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Register copy and block state held by the bench's own model
    // ------------------------------------------------------------------
    logic [1:0]  bg_reg  = 2'd1;
    logic [8:0]  zc_reg  = 9'd2;
    logic [13:0] fill_reg = 14'd0;
    logic [14:0] k0_reg  = 15'd0;
    logic [14:0] ncb_reg = 15'd25344;
    logic [3:0]  qm_reg  = 4'd2;

    logic signed [7:0]  llr_mem [nlrr_pkg::DEF_MAX_LLRS];
    logic signed [11:0] soft_mem [nlrr_pkg::DEF_MAX_BUFFER];
    int                 llrs_held = 0;

    word_t              pending_words [$];
    logic signed [11:0] soft_expect_q [$];
    int                 err_cnt = 0;

    // per-phase idle switches: 0 means back-to-back
    bit src_gaps = 1'b0;
    bit snk_stalls = 1'b0;

    initial
    begin
        for (int p = 0; p < nlrr_pkg::DEF_MAX_BUFFER; p++)
            soft_mem[p] = '0;
    end

    // De-interleave the held LLRs, clear the buffer, mark fillers and
    // accumulate along the circular walk from k0.
    task automatic rebuild_block();
        int e, qm, rowlen, src, zc, fend, fstart, lo, ncb, hi, nfill, pos, acc;
        logic signed [7:0] ordered [];
        e = llrs_held;
        qm = (qm_reg == 0) ? 1 : int'(qm_reg);
        rowlen = e / qm;
        ordered = new[(e > 0) ? e : 1];
        for (int i = 0; i < e; i++)
        begin
            src = i / qm + (i % qm) * rowlen;
            ordered[i] = (src < nlrr_pkg::DEF_MAX_LLRS) ? llr_mem[src] : 8'sd0;
        end
        zc = int'(zc_reg);
        fend = ((bg_reg == 2'd2) ? 10 : 22) * zc - 2 * zc;
        fstart = fend - int'(fill_reg);
        for (int p = 0; p < nlrr_pkg::DEF_MAX_BUFFER; p++)
            soft_mem[p] = '0;
        lo = (fstart < 0) ? 0 : fstart;
        for (int p = lo; p < fend && p < nlrr_pkg::DEF_MAX_BUFFER; p++)
            soft_mem[p] = nlrr_pkg::SOFT_MAX;
        ncb = (ncb_reg == 0) ? 1 : int'(ncb_reg);
        if (ncb > nlrr_pkg::DEF_MAX_BUFFER)
            ncb = nlrr_pkg::DEF_MAX_BUFFER;
        hi = (fend < ncb) ? fend : ncb;
        nfill = (hi > lo) ? hi - lo : 0;
        if (nfill >= ncb)
            return;    // whole buffer is filler: LLRs dropped
        pos = int'(k0_reg) % ncb;
        for (int i = 0; i < e; i++)
        begin
            while (pos >= lo && pos < fend)
            begin
                pos++;
                if (pos >= ncb)
                    pos = 0;
            end
            acc = int'(soft_mem[pos]) + int'(ordered[i]);
            if (acc > 2047)
                acc = 2047;
            if (acc < -2048)
                acc = -2048;
            soft_mem[pos] = acc[11:0];
            pos++;
            if (pos >= ncb)
                pos = 0;
        end
    endtask

    // Model update on every accepted input word.
    always @(posedge clk)
    begin
        if (rst_n && items_if.valid && items_if.ready)
        begin
            if (items_if.kind == nlrr_pkg::KIND_PUSH)
            begin
                if (llrs_held < nlrr_pkg::DEF_MAX_LLRS)
                begin
                    llr_mem[llrs_held] = items_if.llr;
                    llrs_held++;
                end
                if (items_if.last)
                begin
                    rebuild_block();
                    llrs_held = 0;
                end
            end
            else
            begin
                // last on a read word is ignored
                soft_expect_q = {soft_expect_q, soft_mem[items_if.read_index]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: one word per handshake, random gap drawn per word
    // ------------------------------------------------------------------
    int    src_gap = 0;
    word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_if.valid      <= 1'b0;
            items_if.kind       <= nlrr_pkg::KIND_PUSH;
            items_if.llr        <= '0;
            items_if.last       <= 1'b0;
            items_if.read_index <= '0;
            src_gap             <= 0;
        end
        else if (!items_if.valid || items_if.ready)
        begin
            if (src_gap > 0)
            begin
                src_gap        <= src_gap - 1;
                items_if.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                next_word = pending_words.pop_front();
                items_if.valid      <= 1'b1;
                items_if.kind       <= next_word.kind;
                items_if.llr        <= next_word.llr;
                items_if.last       <= next_word.last;
                items_if.read_index <= next_word.idx;
                src_gap <= src_gaps ? $urandom_range(0, 5) : 0;
            end
            else
                items_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compare against oldest expectation
    // ------------------------------------------------------------------
    int               snk_stall = 0;
    int               stall_draw;
    logic signed [11:0] want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b1;
            snk_stall        <= 0;
        end
        else if (results_if.valid && results_if.ready)
        begin
            if (soft_expect_q.size() == 0)
            begin
                $error("unexpected word: soft_value actual %0d", results_if.soft_value);
                err_cnt++;
            end
            else
            begin
                want = soft_expect_q.pop_front();
                if (results_if.soft_value !== want)
                begin
                    $error("soft_value mismatch: expected %0d actual %0d",
                           want, results_if.soft_value);
                    err_cnt++;
                end
            end
            stall_draw = snk_stalls ? $urandom_range(0, 5) : 0;
            snk_stall        <= stall_draw;
            results_if.ready <= (stall_draw == 0);
        end
        else if (snk_stall > 0)
        begin
            snk_stall        <= snk_stall - 1;
            results_if.ready <= (snk_stall == 1);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] reg_idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nlrr_pkg::CFG_AW'(reg_idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input int bg, input int zc, input int f, input int k0,
                            input int ncb, input int qm);
        reg_write(nlrr_pkg::REG_BASE_GRAPH, bg);
        reg_write(nlrr_pkg::REG_LIFTING_SIZE, zc);
        reg_write(nlrr_pkg::REG_FILLER_BITS, f);
        reg_write(nlrr_pkg::REG_START_OFFSET, k0);
        reg_write(nlrr_pkg::REG_BUFFER_SIZE, ncb);
        reg_write(nlrr_pkg::REG_MOD_ORDER, qm);
        bg_reg = bg; zc_reg = zc; fill_reg = f; k0_reg = k0; ncb_reg = ncb; qm_reg = qm;
    endtask

    task automatic add_push(input logic signed [7:0] v, input logic lst);
        word_t w;
        w.kind = nlrr_pkg::KIND_PUSH; w.llr = v; w.last = lst;
        w.idx = $urandom_range(0, 32767);
        pending_words = {pending_words, w};
    endtask

    task automatic add_read(input int idx, input logic lst);
        word_t w;
        w.kind = nlrr_pkg::KIND_READ; w.llr = $urandom_range(0, 255); w.last = lst;
        w.idx = idx;
        pending_words = {pending_words, w};
    endtask

    // Each phase ends on a read, so its result means the pass has finished.
    task automatic drain();
        while (pending_words.size() > 0 || items_if.valid || soft_expect_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int bg, zc, f, k0, ncb, qm, e, span, sel;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset geometry, extreme LLRs, read with last set
        set_regs(1, 2, 0, 0, 25344, 2);
        add_push(8'sd127, 1'b0);
        add_push(-8'sd128, 1'b0);
        add_push(8'sd0, 1'b0);
        add_push(-8'sd1, 1'b0);
        add_push(8'sd1, 1'b1);
        for (int i = 0; i < 6; i++)
            add_read(i, 1'b0);
        add_read(32767, 1'b1);
        drain();

        // Directed: BG2, largest Zc, filler range clipped below zero,
        // k0 at the top so the walk wraps and skips the fillers
        src_gaps = 1'b1;
        set_regs(2, 384, 8447, 25343, 25344, 8);
        for (int i = 0; i < 9; i++)
            add_push((i % 2) ? -8'sd128 : 8'sd127, i == 8);
        add_read(25343, 1'b0);
        add_read(0, 1'b0);
        add_read(3071, 1'b0);
        add_read(3072, 1'b0);
        add_read(3073, 1'b0);
        drain();

        // Random phases: one block each, mostly small geometry
        for (int ph = 0; ph < 15; ph++)
        begin
            src_gaps   = $urandom_range(0, 1);
            snk_stalls = $urandom_range(0, 1);
            bg = $urandom_range(0, 3);
            zc = ($urandom_range(0, 3) == 0) ? 384 : $urandom_range(2, 20);
            sel = $urandom_range(0, 5);
            f = (sel == 0) ? 8447 : (sel == 1) ? 0 : $urandom_range(0, 40);
            sel = $urandom_range(0, 5);
            ncb = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 25344 :
                  (sel == 3) ? 32767 : $urandom_range(1, 64);
            k0 = ($urandom_range(0, 4) == 0) ? 25343 : $urandom_range(0, 80);
            qm = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            set_regs(bg, zc, f, k0, ncb, qm);

            e = $urandom_range(1, 60);
            for (int i = 0; i < e; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    add_read($urandom_range(0, 32767), $urandom_range(0, 1));
                sel = $urandom_range(0, 3);
                add_push((sel == 0) ? 8'sd127 : (sel == 1) ? -8'sd128 :
                         $urandom_range(0, 255), i == e - 1);
            end
            span = (ncb == 0) ? 1 : (ncb > 200) ? 200 : ncb;
            for (int i = 0; i < 20; i++)
            begin
                sel = $urandom_range(0, 3);
                if (sel < 2)
                    add_read($urandom_range(0, span - 1), $urandom_range(0, 1));
                else if (sel == 2)
                    add_read((k0 + $urandom_range(0, 70)) % 32768, 1'b0);
                else
                    add_read($urandom_range(0, 32767), $urandom_range(0, 1));
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0 && soft_expect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: fails the run if it has not finished by the time limit.
    initial
    begin
        #10000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/nlrr_pkg.sv
sv/nlrr_in_if.sv
sv/nlrr_out_if.sv
sv/nlrr_ram.sv
sv/nlrr_ctrl.sv
sv/nlrr_dp.sv
sv/nr_ldpc_rate_recovery.sv
verif/nr_ldpc_rate_recovery_test.sv
